### design/rhist_pkg.sv
// ----------------------------------------------------------------------------
// rhist_pkg
// Shared types, codes and constants of the per-device RSSI history table.
// ----------------------------------------------------------------------------
package rhist_pkg;

	localparam int DEVICES_DEF = 64;
	localparam int SLOTS_DEF   = 32;

	localparam int REQ_W     = 2;
	localparam int LEN_W     = 16;
	localparam int MAC_W     = 48;
	localparam int RSSI_W    = 8;
	localparam int TIME_W    = 32;
	localparam int DEVIDX_W  = 6;
	localparam int SLOTIDX_W = 5;
	localparam int STATUS_W  = 4;
	localparam int COUNT_W   = 7;
	localparam int SECS_W    = 23;
	localparam int WIN_W     = 16;
	localparam int ALPHA_W   = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;
	localparam int DIV_MUL_W = 29;

	localparam logic [LEN_W-1:0]   UNRELIABLE_LEN = 16'd12;
	localparam logic [WIN_W-1:0]   WINDOW_RST     = 16'd1000;
	localparam logic [ALPHA_W-1:0] ALPHA_RST      = 9'd77;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 9'd256;
	// x / 1000 for any 32-bit x is (x * ceil(2^38 / 1000)) >> 38
	localparam logic [DIV_MUL_W-1:0] MS_DIV_MUL   = 29'd274877907;
	localparam int                   MS_DIV_SHIFT = 38;

	typedef enum logic [REQ_W-1:0] {
		REQ_OBSERVE = 2'd0,
		REQ_READ    = 2'd1,
		REQ_CLEAR   = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_NEW       = 4'd0,
		STS_APPENDED  = 4'd1,
		STS_AVERAGED  = 4'd2,
		STS_TABLEFULL = 4'd3,
		STS_HISTFULL  = 4'd4,
		STS_IGNORED   = 4'd5,
		STS_READOK    = 4'd6,
		STS_NOENTRY   = 4'd7,
		STS_CLEARED   = 4'd8
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW = 1'b0,
		CFG_ALPHA  = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MRD,
		S_MCMP,
		S_SRD,
		S_SCMP,
		S_MUL1,
		S_MUL2,
		S_INS,
		S_CLR,
		S_RRD,
		S_RWAIT,
		S_DIV,
		S_DONE
	} state_t;

endpackage

### design/rhist_req_if.sv
// ----------------------------------------------------------------------------
// rhist_req_if
// Request channel: observe, read or clear word with valid/ready.
// ----------------------------------------------------------------------------
interface rhist_req_if;
	import rhist_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [REQ_W-1:0]            req_type;
	logic [LEN_W-1:0]            rx_length;
	logic [MAC_W-1:0]            src_mac;
	logic signed [RSSI_W-1:0]    rssi;
	logic [TIME_W-1:0]           now_ms;
	logic [DEVIDX_W-1:0]         device_index;
	logic [SLOTIDX_W-1:0]        slot_index;

	modport source (output valid, req_type, rx_length, src_mac, rssi, now_ms,
		device_index, slot_index, input ready);
	modport sink (input valid, req_type, rx_length, src_mac, rssi, now_ms,
		device_index, slot_index, output ready);
endinterface

### design/rhist_rsp_if.sv
// ----------------------------------------------------------------------------
// rhist_rsp_if
// Result channel: one word per request with valid/ready.
// ----------------------------------------------------------------------------
interface rhist_rsp_if;
	import rhist_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [STATUS_W-1:0]         status;
	logic [DEVIDX_W-1:0]         entry_index;
	logic [COUNT_W-1:0]          device_count;
	logic [MAC_W-1:0]            mac_out;
	logic signed [RSSI_W-1:0]    rssi_out;
	logic [SECS_W-1:0]           seconds_since;

	modport source (output valid, status, entry_index, device_count, mac_out,
		rssi_out, seconds_since, input ready);
	modport sink (input valid, status, entry_index, device_count, mac_out,
		rssi_out, seconds_since, output ready);
endinterface

### design/per_device_rssi_history_table_top.sv
// ----------------------------------------------------------------------------
// per_device_rssi_history_table_top
// Table of sniffed MACs, each with a short history of strength samples.
//
// req carries observe, read and clear words; rsp returns one word for each.
// cfg_we/cfg_idx/cfg_wdata write window_ms (index 0) and alpha_q8 (index 1).
// Observe: the MAC search reads and compares the filled entries in turn,
// then the slot walk reads and checks the slots of the row in turn; insertion
// of a new MAC writes its first sample and clears the rest of the row.
// Averaging uses one shared multiplier in S_MUL1 and S_MUL2. Read: the RAMs
// are read, then the entry is captured, then the divide by 1000 (multiply by
// a scaled reciprocal) follows when the slot holds a sample.
// Clear: goes straight to the result.
// One word is in work at a time; req.ready is high only when idle.
// The result waits in an output register; while rsp stalls, the block holds
// the next result and takes no new word. Reset empties the table at once
// (the fill count drops to zero, rows are cleared as entries are inserted),
// so no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_device_rssi_history_table_top #(
	parameter int DEVICES = rhist_pkg::DEVICES_DEF,
	parameter int SLOTS   = rhist_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rhist_req_if.sink                         req,
	rhist_rsp_if.source                       rsp,
	input  logic                              cfg_we,
	input  logic [rhist_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rhist_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
	import rhist_pkg::*;

	localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int FW = $clog2(DEVICES + 1);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SDEPTH = DEVICES * SLOTS;
	localparam int AW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int SAMP_W = RSSI_W + TIME_W;
	localparam int DP_W = TIME_W + DIV_MUL_W;

	state_t state_q, state_nx;

	logic [WIN_W-1:0]          window_q;
	logic [ALPHA_W-1:0]        alpha_q;
	logic [FW-1:0]             fill_q;
	logic [DW-1:0]             d_q;
	logic [SW-1:0]             s_q;
	logic [MAC_W-1:0]          mac_q;
	logic signed [RSSI_W-1:0]  rssi_q;
	logic [TIME_W-1:0]         now_q;
	logic signed [RSSI_W-1:0]  old_q;
	logic [TIME_W-1:0]         stamp_q;
	logic signed [17:0]        prod_q;
	logic [TIME_W-1:0]         num_q;
	logic [SECS_W-1:0]         quot_q;

	logic [STATUS_W-1:0]       res_status_q;
	logic [DEVIDX_W-1:0]       res_entry_q;
	logic [MAC_W-1:0]          res_mac_q;
	logic signed [RSSI_W-1:0]  res_rssi_q;

	logic                      rsp_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic [DEVIDX_W-1:0]       entry_q;
	logic [COUNT_W-1:0]        count_q;
	logic [MAC_W-1:0]          mac_out_q;
	logic signed [RSSI_W-1:0]  rssi_out_q;
	logic [SECS_W-1:0]         secs_q;

	// RAM ports
	logic                      mac_we, mac_re;
	logic [MAC_W-1:0]          mac_rdata;
	logic                      samp_we, samp_re;
	logic [SAMP_W-1:0]         samp_wdata, samp_rdata;
	logic [AW-1:0]             samp_addr;

	logic signed [RSSI_W-1:0]  rd_strength;
	logic [TIME_W-1:0]         rd_stamp;
	logic                      slot_empty, slot_young, slot_last, dev_last;
	logic                      accept, out_free;
	logic                      rd_bad;
	logic [ALPHA_W-1:0]        a_sat;
	logic signed [9:0]         mul_a;
	logic signed [RSSI_W-1:0]  mul_b;
	logic signed [17:0]        product;
	logic signed [18:0]        blend_sum, blend_adj;
	logic signed [RSSI_W-1:0]  blended;
	logic [DP_W-1:0]           div_prod;

	rhist_ram #(.WIDTH(MAC_W), .DEPTH(DEVICES), .AW(DW)) u_mac_ram (
		.clk  (clk),
		.we   (mac_we),
		.waddr(d_q),
		.wdata(mac_q),
		.re   (mac_re),
		.raddr(d_q),
		.rdata(mac_rdata)
	);

	rhist_ram #(.WIDTH(SAMP_W), .DEPTH(SDEPTH), .AW(AW)) u_samp_ram (
		.clk  (clk),
		.we   (samp_we),
		.waddr(samp_addr),
		.wdata(samp_wdata),
		.re   (samp_re),
		.raddr(samp_addr),
		.rdata(samp_rdata)
	);

	assign samp_addr   = AW'(d_q) * AW'(SLOTS) + AW'(s_q);
	assign rd_strength = samp_rdata[SAMP_W-1 -: RSSI_W];
	assign rd_stamp    = samp_rdata[TIME_W-1:0];
	assign slot_empty  = (rd_strength == '0);
	assign slot_young  = ((now_q - rd_stamp) < {{(TIME_W-WIN_W){1'b0}}, window_q});
	assign slot_last   = (32'(s_q) == SLOTS - 1);
	assign dev_last    = ((FW'(d_q) + 1'b1) == fill_q);
	assign accept      = req.valid && req.ready;
	assign out_free    = !rsp_valid_q || rsp.ready;
	assign rd_bad      = ({{(32-DEVIDX_W){1'b0}}, req.device_index} >= 32'(fill_q))
		|| (32'(req.device_index) >= DEVICES) || (32'(req.slot_index) >= SLOTS);

	// shared multiplier for the moving average
	assign a_sat     = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign product   = mul_a * mul_b;
	assign blend_sum = 19'(prod_q) + 19'(product);
	assign blend_adj = blend_sum + (blend_sum[18] ? 19'sd255 : 19'sd0);
	assign blended   = RSSI_W'(blend_adj >>> 8);

	// age in ms divided by 1000 through the scaled reciprocal
	assign div_prod = DP_W'(num_q) * DP_W'(MS_DIV_MUL);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_OBSERVE: begin
							if (32'(fill_q) >= DEVICES || req.rx_length == UNRELIABLE_LEN)
								state_nx = S_DONE;
							else if (fill_q == '0)
								state_nx = S_INS;
							else
								state_nx = S_MRD;
						end
						REQ_READ: state_nx = rd_bad ? S_DONE : S_RRD;
						default:  state_nx = S_DONE;
					endcase
				end
			end
			S_MRD:  state_nx = S_MCMP;
			S_MCMP: begin
				if (mac_rdata == mac_q)
					state_nx = S_SRD;
				else if (dev_last)
					state_nx = S_INS;
				else
					state_nx = S_MRD;
			end
			S_SRD:  state_nx = S_SCMP;
			S_SCMP: begin
				if (slot_empty)
					state_nx = S_DONE;
				else if (slot_young)
					state_nx = S_MUL1;
				else if (slot_last)
					state_nx = S_DONE;
				else
					state_nx = S_SRD;
			end
			S_MUL1: state_nx = S_MUL2;
			S_MUL2: state_nx = S_DONE;
			S_INS:  state_nx = (SLOTS == 1) ? S_DONE : S_CLR;
			S_CLR:  state_nx = slot_last ? S_DONE : S_CLR;
			S_RRD:  state_nx = S_RWAIT;
			S_RWAIT: state_nx = slot_empty ? S_DONE : S_DIV;
			S_DIV:  state_nx = S_DONE;
			S_DONE: state_nx = out_free ? S_IDLE : S_DONE;
			default: state_nx = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready  = 1'b0;
		mac_we     = 1'b0;
		mac_re     = 1'b0;
		samp_we    = 1'b0;
		samp_re    = 1'b0;
		samp_wdata = {rssi_q, now_q};
		mul_a      = {1'b0, a_sat};
		mul_b      = rssi_q;
		unique case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_MRD:  mac_re = 1'b1;
			S_SRD:  samp_re = 1'b1;
			S_SCMP: samp_we = slot_empty;
			S_MUL2: begin
				mul_a      = {1'b0, ALPHA_ONE - a_sat};
				mul_b      = old_q;
				samp_we    = 1'b1;
				samp_wdata = {blended, stamp_q};
			end
			S_INS: begin
				mac_we  = 1'b1;
				samp_we = 1'b1;
			end
			S_CLR: begin
				samp_we    = 1'b1;
				samp_wdata = '0;
			end
			S_RRD: begin
				mac_re  = 1'b1;
				samp_re = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			alpha_q  <= ALPHA_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_WINDOW: window_q <= cfg_wdata;
				CFG_ALPHA:  alpha_q  <= cfg_wdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept && req.req_type == REQ_CLEAR)
				fill_q <= '0;
			if ((state_q == S_INS && SLOTS == 1) || (state_q == S_CLR && slot_last))
				fill_q <= fill_q + 1'b1;
			if (state_q == S_DONE && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mac_q        <= req.src_mac;
				rssi_q       <= req.rssi;
				now_q        <= req.now_ms;
				d_q          <= '0;
				s_q          <= '0;
				res_entry_q  <= '0;
				res_mac_q    <= '0;
				res_rssi_q   <= '0;
				quot_q       <= '0;
				res_status_q <= STS_IGNORED;
				if (accept) begin
					case (req.req_type)
						REQ_OBSERVE: begin
							if (32'(fill_q) >= DEVICES)
								res_status_q <= STS_TABLEFULL;
						end
						REQ_READ: begin
							res_entry_q <= req.device_index;
							d_q <= DW'(req.device_index);
							s_q <= SW'(req.slot_index);
							res_status_q <= rd_bad ? STS_NOENTRY : STS_READOK;
						end
						REQ_CLEAR: res_status_q <= STS_CLEARED;
						default: ;
					endcase
				end
			end
			S_MCMP: begin
				if (mac_rdata == mac_q) begin
					s_q <= '0;
					res_entry_q <= DEVIDX_W'(d_q);
				end else if (dev_last) begin
					d_q <= DW'(fill_q);
				end else begin
					d_q <= d_q + 1'b1;
				end
			end
			S_SCMP: begin
				old_q   <= rd_strength;
				stamp_q <= rd_stamp;
				if (slot_empty)
					res_status_q <= STS_APPENDED;
				else if (!slot_young && slot_last)
					res_status_q <= STS_HISTFULL;
				else if (!slot_young)
					s_q <= s_q + 1'b1;
			end
			S_MUL1: prod_q <= product;
			S_MUL2: res_status_q <= STS_AVERAGED;
			S_INS: begin
				s_q <= s_q + 1'b1;
				res_entry_q  <= DEVIDX_W'(d_q);
				res_status_q <= STS_NEW;
			end
			S_CLR: s_q <= s_q + 1'b1;
			S_RWAIT: begin
				res_mac_q  <= mac_rdata;
				res_rssi_q <= rd_strength;
				num_q      <= now_q - rd_stamp;
			end
			S_DIV: quot_q <= div_prod[MS_DIV_SHIFT +: SECS_W];
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q   <= res_status_q;
			entry_q    <= res_entry_q;
			count_q    <= COUNT_W'(fill_q);
			mac_out_q  <= res_mac_q;
			rssi_out_q <= res_rssi_q;
			secs_q     <= quot_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.entry_index   = entry_q;
	assign rsp.device_count  = count_q;
	assign rsp.mac_out       = mac_out_q;
	assign rsp.rssi_out      = rssi_out_q;
	assign rsp.seconds_since = secs_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= DEVICES)
		else $error("fill count beyond table depth");

	a_search_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MCMP |-> FW'(d_q) < fill_q)
		else $error("MAC search past filled entries");

	a_slot_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCMP || state_q == S_CLR |-> 32'(s_q) < SLOTS)
		else $error("slot index beyond row");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		mac_we |-> 32'(fill_q) < DEVICES)
		else $error("insert into full table");
endmodule

### design/rhist_ram.sv
// ----------------------------------------------------------------------------
// rhist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rhist_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
